/* design/spnc_pkg.sv */
package spnc_pkg;

  localparam int COORD_W = 32;
  localparam int REG_W = 64;
  localparam int IDX_W = 3;
  localparam int NUM_REGS = 8;
  localparam int PIX_W = 16;
  // quotient clamp in panel mapping is +/- 2^Q_LIMIT_LOG2
  localparam int Q_LIMIT_LOG2 = 45;
  // epsilon is one ten-thousandth of unity
  localparam int EPS_DIV = 10000;

  typedef enum logic [IDX_W-1:0] {
    REG_ROW_X_FIRST  = 3'd0,
    REG_ROW_X_SECOND = 3'd1,
    REG_ROW_Y_FIRST  = 3'd2,
    REG_ROW_Y_SECOND = 3'd3,
    REG_ROW_W_FIRST  = 3'd4,
    REG_ROW_W_SECOND = 3'd5,
    REG_VIEWPORT     = 3'd6,
    REG_NEAR_PLANE   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic                       func;
    logic signed [COORD_W-1:0]  start_x;
    logic signed [COORD_W-1:0]  start_y;
    logic signed [COORD_W-1:0]  start_z;
    logic signed [COORD_W-1:0]  end_x;
    logic signed [COORD_W-1:0]  end_y;
    logic signed [COORD_W-1:0]  end_z;
  } in_item_t;

  typedef struct packed {
    logic                       visible;
    logic signed [COORD_W-1:0]  start_px;
    logic signed [COORD_W-1:0]  start_py;
    logic signed [COORD_W-1:0]  end_px;
    logic signed [COORD_W-1:0]  end_py;
  } out_item_t;

  // one matrix row as seen by a transform lane
  typedef struct packed {
    logic signed [COORD_W-1:0] wx;
    logic signed [COORD_W-1:0] wy;
    logic signed [COORD_W-1:0] wz;
    logic signed [COORD_W-1:0] wc;
  } row_w_t;

endpackage

/* design/spnc_if.sv */
interface spnc_in_if;
  logic                 valid;
  logic                 ready;
  spnc_pkg::in_item_t   data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface spnc_out_if;
  logic                 valid;
  logic                 ready;
  spnc_pkg::out_item_t  data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* design/spnc_row.sv */
module spnc_row #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  spnc_pkg::row_w_t        wt,
  input  logic signed [31:0]      x,
  input  logic signed [31:0]      y,
  input  logic signed [31:0]      z,
  output logic signed [31:0]      res
);

  localparam int SW = 66;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC_BITS - 1);

  logic signed [63:0] p0_r, p1_r, p2_r;
  logic signed [31:0] c_r;
  logic signed [SW-1:0] sum;
  logic signed [31:0] res_nxt;
  logic signed [31:0] res_r;

  function automatic logic signed [SW-1:0] rnd(input logic signed [63:0] p);
    logic signed [SW-1:0] t;
    t = $signed({{(SW-64){p[63]}}, p}) + HALF;
    return t >>> FRAC_BITS;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= wt.wx * x;
      p1_r <= wt.wy * y;
      p2_r <= wt.wz * z;
      c_r  <= wt.wc;
    end
  end

  always_comb begin
    sum = rnd(p0_r) + rnd(p1_r) + rnd(p2_r) + $signed({{(SW-32){c_r[31]}}, c_r});
    if (!sum[SW-1] && (|sum[SW-2:31])) begin
      res_nxt = 32'sh7fffffff;
    end else if (sum[SW-1] && !(&sum[SW-2:31])) begin
      res_nxt = 32'sh80000000;
    end else begin
      res_nxt = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

/* design/spnc_div.sv */
module spnc_div #(
  parameter int NW = 50,
  parameter int DW = 34,
  parameter int QW = 17,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic [NW-1:0] n,
  input  logic [DW-1:0] d,
  input  logic [SW-1:0] side_in,
  output logic [QW-1:0] q,
  output logic          rem_nz,
  output logic [SW-1:0] side_out
);

  // restoring division, one quotient bit per stage
  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] nq_r   [QW];
  logic [DW-1:0] d_r    [QW];
  logic [SW-1:0] side_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_i;
    logic [QW-1:0] nq_i;
    logic [DW-1:0] d_i;
    logic [SW-1:0] side_i;
    logic [DW:0]   trial;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_i  = DW'(n >> QW);
      assign nq_i   = QW'(n);
      assign d_i    = d;
      assign side_i = side_in;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign nq_i   = nq_r[k-1];
      assign d_i    = d_r[k-1];
      assign side_i = side_r[k-1];
    end

    always_comb begin
      trial = {rem_i, nq_i[QW-1]};
      take  = trial >= {1'b0, d_i};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? DW'(trial - {1'b0, d_i}) : trial[DW-1:0];
        nq_r[k]   <= {nq_i[QW-2:0], take};
        d_r[k]    <= d_i;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k] <= '0;
      end else if (en) begin
        side_r[k] <= side_i;
      end
    end
  end

  assign q        = nq_r[QW-1];
  assign rem_nz   = |rem_r[QW-1];
  assign side_out = side_r[QW-1];

endmodule

/* design/spnc_panel.sv */
module spnc_panel #(
  parameter int FRAC_BITS = 16,
  parameter int SW = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic signed [34:0] num,
  input  logic signed [33:0] w,
  input  logic [15:0]        lo,
  input  logic [15:0]        size,
  input  logic [SW-1:0]      side_in,
  output logic signed [31:0] res,
  output logic [SW-1:0]      side_out
);

  localparam int NW = 35 + FRAC_BITS;
  localparam int DW = 35;
  localparam int MW = (NW + 1 > 47) ? NW + 1 : 47;
  localparam logic [MW-1:0] LIM = MW'(1) << spnc_pkg::Q_LIMIT_LOG2;

  logic [34:0]   mag;
  logic [NW-1:0] n1_r;
  logic [DW-1:0] d1_r;
  logic [SW:0]   sd1_r;

  logic [NW-1:0] q_d;
  logic          rnz_d;
  logic [SW:0]   sd_d;

  logic [MW-1:0]       magq;
  logic signed [46:0]  qs;
  logic signed [46:0]  q2_r;
  logic [SW-1:0]       sd2_r;
  logic signed [63:0]  prod_r;
  logic [SW-1:0]       sd3_r;
  logic signed [63:0]  base;
  logic signed [63:0]  sum;
  logic signed [31:0]  res_nxt;
  logic signed [31:0]  res_r;
  logic [SW-1:0]       sd4_r;

  assign mag = num[34] ? 35'(-num) : 35'(num);

  always_ff @(posedge clk) begin
    if (en) begin
      n1_r  <= NW'(mag) << FRAC_BITS;
      d1_r  <= {w, 1'b0};
    end
  end

  spnc_div #(.NW(NW), .DW(DW), .QW(NW), .SW(SW + 1)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .n        (n1_r),
    .d        (d1_r),
    .side_in  (sd1_r),
    .q        (q_d),
    .rem_nz   (rnz_d),
    .side_out (sd_d)
  );

  // negative numerators round toward minus infinity
  always_comb begin
    magq = MW'(q_d) + MW'(sd_d[0] & rnz_d);
    if (magq > LIM) begin
      magq = LIM;
    end
    qs = sd_d[0] ? -47'(magq) : 47'(magq);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q2_r   <= qs;
      prod_r <= q2_r * $signed({1'b0, size});
    end
  end

  always_comb begin
    base = $signed(64'(lo) << FRAC_BITS);
    sum  = base + prod_r;
    if (!sum[63] && (|sum[62:31])) begin
      res_nxt = 32'sh7fffffff;
    end else if (sum[63] && !(&sum[62:31])) begin
      res_nxt = 32'sh80000000;
    end else begin
      res_nxt = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd1_r <= '0;
      sd2_r <= '0;
      sd3_r <= '0;
      sd4_r <= '0;
    end else if (en) begin
      sd1_r <= {side_in, num[34]};
      sd2_r <= sd_d[SW:1];
      sd3_r <= sd2_r;
      sd4_r <= sd3_r;
    end
  end

  assign res      = res_r;
  assign side_out = sd4_r;

endmodule

/* design/segment_project_near_clip.sv */
// segment_project_near_clip
// in_ch carries one point or segment request (func, start and end world
// coordinates); out_ch returns one result per request, in order: visible and
// the panel coordinates of both ends, zero where not visible or unused.
// cfg_we/cfg_idx/cfg_wdata write the matrix rows, viewport and near plane;
// write them only while no request is in flight.
// Throughput: one request per cycle while the skid register is empty. Six
// transform lanes feed a pipelined clip divider and four pipelined panel
// lanes; the dividers each take one quotient bit a stage: the clip divider
// (FRAC_BITS+1 stages) and the panel dividers (35+FRAC_BITS stages).
// Reset (rst_n low, synchronous) empties the pipeline and loads the identity
// x and y rows, the constant-one w row, an empty viewport and a zero near plane.
// When out_ch stalls, one more result is parked in a skid register; after
// that the whole pipeline holds and in_ch.ready drops until the sink takes one.
module segment_project_near_clip #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  spnc_in_if.sink                      in_ch,
  spnc_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [spnc_pkg::IDX_W-1:0]   cfg_idx,
  input  logic [spnc_pkg::REG_W-1:0]   cfg_wdata
);

  localparam longint EPS_L = ((longint'(1) <<< FRAC_BITS) + spnc_pkg::EPS_DIV / 2)
                             / spnc_pkg::EPS_DIV;
  localparam longint EPS_V = (EPS_L < 1) ? 1 : EPS_L;
  localparam logic signed [33:0] EPS_S = 34'(EPS_V);
  localparam int QT = FRAC_BITS + 1;
  localparam int MXW = 35 + FRAC_BITS;
  localparam logic signed [MXW-1:0] HALF = MXW'(1) <<< (FRAC_BITS - 1);

  typedef struct packed {
    logic               v;
    logic               seg;
    logic               vis;
    logic               clip;
    logic               ab;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] aw;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bw;
  } clip_side_t;

  typedef struct packed {
    logic v;
    logic vis;
    logic seg;
  } pan_side_t;

  logic [spnc_pkg::REG_W-1:0] cfg_r [spnc_pkg::NUM_REGS];

  logic en;
  logic skid_v_r, out_v_r;
  spnc_pkg::out_item_t skid_d_r, out_d_r, pd;

  spnc_pkg::in_item_t s1_r;
  logic s1_v_r, s2_v_r, s3_v_r, s2_seg_r, s3_seg_r;

  spnc_pkg::row_w_t wt_x, wt_y, wt_w;
  logic signed [31:0] ax, ay, aw, bx, by, bw;

  logic [15:0] vp_minx, vp_miny, vp_wid, vp_hgt;
  logic [31:0] near;
  logic signed [33:0] plane;

  logic signed [33:0] aw_e, bw_e, numa, den;
  logic [33:0] magn, magd;
  logic ab, bb;
  clip_side_t cs4;
  clip_side_t s4_side_r;
  logic [33+FRAC_BITS:0] n4_r;
  logic [33:0] d4_r;

  logic [QT-1:0] t_d;
  logic [$bits(clip_side_t)-1:0] cs_div;
  clip_side_t cs5;
  clip_side_t s5_side_r;
  logic signed [MXW-1:0] mx_r, my_r;
  logic signed [32:0] dx, dy;

  logic signed [MXW-1:0] rx, ry;
  logic signed [33:0] cx, cy, a_x, a_y, a_w, b_x, b_y, b_w;
  logic signed [34:0] num0_r, num1_r, num2_r, num3_r;
  logic signed [33:0] wa_r, wb_r;
  pan_side_t s6_side_r;

  logic signed [31:0] r0, r1, r2, r3;
  logic [$bits(pan_side_t)-1:0] pside_v;
  pan_side_t pside;
  logic out_free, pipe_push;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[spnc_pkg::REG_ROW_X_FIRST]  <= 64'h0000_0000_0001_0000;
      cfg_r[spnc_pkg::REG_ROW_X_SECOND] <= '0;
      cfg_r[spnc_pkg::REG_ROW_Y_FIRST]  <= 64'h0001_0000_0000_0000;
      cfg_r[spnc_pkg::REG_ROW_Y_SECOND] <= '0;
      cfg_r[spnc_pkg::REG_ROW_W_FIRST]  <= '0;
      cfg_r[spnc_pkg::REG_ROW_W_SECOND] <= 64'h0001_0000_0000_0000;
      cfg_r[spnc_pkg::REG_VIEWPORT]     <= '0;
      cfg_r[spnc_pkg::REG_NEAR_PLANE]   <= '0;
    end else if (cfg_we) begin
      if (cfg_idx == spnc_pkg::REG_NEAR_PLANE) begin
        cfg_r[cfg_idx] <= {32'd0, cfg_wdata[31:0]};
      end else begin
        cfg_r[cfg_idx] <= cfg_wdata;
      end
    end
  end

  always_comb begin
    wt_x.wx = cfg_r[spnc_pkg::REG_ROW_X_FIRST][31:0];
    wt_x.wy = cfg_r[spnc_pkg::REG_ROW_X_FIRST][63:32];
    wt_x.wz = cfg_r[spnc_pkg::REG_ROW_X_SECOND][31:0];
    wt_x.wc = cfg_r[spnc_pkg::REG_ROW_X_SECOND][63:32];
    wt_y.wx = cfg_r[spnc_pkg::REG_ROW_Y_FIRST][31:0];
    wt_y.wy = cfg_r[spnc_pkg::REG_ROW_Y_FIRST][63:32];
    wt_y.wz = cfg_r[spnc_pkg::REG_ROW_Y_SECOND][31:0];
    wt_y.wc = cfg_r[spnc_pkg::REG_ROW_Y_SECOND][63:32];
    wt_w.wx = cfg_r[spnc_pkg::REG_ROW_W_FIRST][31:0];
    wt_w.wy = cfg_r[spnc_pkg::REG_ROW_W_FIRST][63:32];
    wt_w.wz = cfg_r[spnc_pkg::REG_ROW_W_SECOND][31:0];
    wt_w.wc = cfg_r[spnc_pkg::REG_ROW_W_SECOND][63:32];
    vp_minx = cfg_r[spnc_pkg::REG_VIEWPORT][15:0];
    vp_miny = cfg_r[spnc_pkg::REG_VIEWPORT][31:16];
    vp_wid  = cfg_r[spnc_pkg::REG_VIEWPORT][47:32];
    vp_hgt  = cfg_r[spnc_pkg::REG_VIEWPORT][63:48];
    near    = cfg_r[spnc_pkg::REG_NEAR_PLANE][31:0];
    plane   = (34'(near) < EPS_S) ? EPS_S : $signed(34'(near));
  end

  assign en = !skid_v_r;
  assign in_ch.ready = en;

  // input register and transform lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_ch.valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r     <= in_ch.data;
      s2_seg_r <= s1_r.func;
      s3_seg_r <= s2_seg_r;
    end
  end

  spnc_row #(.FRAC_BITS(FRAC_BITS)) u_row_ax (.clk(clk), .en(en), .wt(wt_x),
    .x(s1_r.start_x), .y(s1_r.start_y), .z(s1_r.start_z), .res(ax));
  spnc_row #(.FRAC_BITS(FRAC_BITS)) u_row_ay (.clk(clk), .en(en), .wt(wt_y),
    .x(s1_r.start_x), .y(s1_r.start_y), .z(s1_r.start_z), .res(ay));
  spnc_row #(.FRAC_BITS(FRAC_BITS)) u_row_aw (.clk(clk), .en(en), .wt(wt_w),
    .x(s1_r.start_x), .y(s1_r.start_y), .z(s1_r.start_z), .res(aw));
  spnc_row #(.FRAC_BITS(FRAC_BITS)) u_row_bx (.clk(clk), .en(en), .wt(wt_x),
    .x(s1_r.end_x), .y(s1_r.end_y), .z(s1_r.end_z), .res(bx));
  spnc_row #(.FRAC_BITS(FRAC_BITS)) u_row_by (.clk(clk), .en(en), .wt(wt_y),
    .x(s1_r.end_x), .y(s1_r.end_y), .z(s1_r.end_z), .res(by));
  spnc_row #(.FRAC_BITS(FRAC_BITS)) u_row_bw (.clk(clk), .en(en), .wt(wt_w),
    .x(s1_r.end_x), .y(s1_r.end_y), .z(s1_r.end_z), .res(bw));

  // plane tests and clip divide operands
  always_comb begin
    aw_e = aw;
    bw_e = bw;
    ab   = aw_e <= plane;
    bb   = bw_e <= plane;
    numa = plane - aw_e;
    den  = bw_e - aw_e;
    magn = numa[33] ? 34'(-numa) : 34'(numa);
    magd = den[33] ? 34'(-den) : 34'(den);
    cs4.v    = s3_v_r;
    cs4.seg  = s3_seg_r;
    cs4.vis  = (vp_wid != '0) && (vp_hgt != '0) &&
               (s3_seg_r ? !(ab && bb) : (aw_e > EPS_S));
    cs4.clip = s3_seg_r && (ab != bb);
    cs4.ab   = ab;
    cs4.ax   = ax;
    cs4.ay   = ay;
    cs4.aw   = aw;
    cs4.bx   = bx;
    cs4.by   = by;
    cs4.bw   = bw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_side_r.v <= 1'b0;
    end else if (en) begin
      s4_side_r.v <= cs4.v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n4_r <= (34 + FRAC_BITS)'(magn) << FRAC_BITS;
      d4_r <= magd;
      {s4_side_r.seg, s4_side_r.vis, s4_side_r.clip, s4_side_r.ab, s4_side_r.ax,
       s4_side_r.ay, s4_side_r.aw, s4_side_r.bx, s4_side_r.by, s4_side_r.bw} <=
        {cs4.seg, cs4.vis, cs4.clip, cs4.ab, cs4.ax, cs4.ay, cs4.aw, cs4.bx,
         cs4.by, cs4.bw};
    end
  end

  // t never exceeds unity, so FRAC_BITS+1 quotient bits suffice
  spnc_div #(.NW(34 + FRAC_BITS), .DW(34), .QW(QT), .SW($bits(clip_side_t))) u_clip_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .n        (n4_r),
    .d        (d4_r),
    .side_in  (s4_side_r),
    .q        (t_d),
    .rem_nz   (),
    .side_out (cs_div)
  );

  assign cs5 = clip_side_t'(cs_div);

  always_comb begin
    dx = 33'(cs5.bx) - 33'(cs5.ax);
    dy = 33'(cs5.by) - 33'(cs5.ay);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_side_r.v <= 1'b0;
    end else if (en) begin
      s5_side_r.v <= cs5.v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r <= $signed({{2{dx[32]}}, dx}) * $signed({1'b0, t_d});
      my_r <= $signed({{2{dy[32]}}, dy}) * $signed({1'b0, t_d});
      {s5_side_r.seg, s5_side_r.vis, s5_side_r.clip, s5_side_r.ab, s5_side_r.ax,
       s5_side_r.ay, s5_side_r.aw, s5_side_r.bx, s5_side_r.by, s5_side_r.bw} <=
        {cs5.seg, cs5.vis, cs5.clip, cs5.ab, cs5.ax, cs5.ay, cs5.aw, cs5.bx,
         cs5.by, cs5.bw};
    end
  end

  // crossing point replaces whichever end lies behind the plane
  always_comb begin
    rx  = (mx_r + HALF) >>> FRAC_BITS;
    ry  = (my_r + HALF) >>> FRAC_BITS;
    cx  = 34'(MXW'(s5_side_r.ax) + rx);
    cy  = 34'(MXW'(s5_side_r.ay) + ry);
    a_x = s5_side_r.ax;
    a_y = s5_side_r.ay;
    a_w = s5_side_r.aw;
    b_x = s5_side_r.bx;
    b_y = s5_side_r.by;
    b_w = s5_side_r.bw;
    if (s5_side_r.clip && s5_side_r.ab) begin
      a_x = cx;
      a_y = cy;
      a_w = plane;
    end else if (s5_side_r.clip) begin
      b_x = cx;
      b_y = cy;
      b_w = plane;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_side_r.v <= 1'b0;
    end else if (en) begin
      s6_side_r.v <= s5_side_r.v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num0_r <= 35'(a_x) + 35'(a_w);
      num1_r <= 35'(a_w) - 35'(a_y);
      num2_r <= 35'(b_x) + 35'(b_w);
      num3_r <= 35'(b_w) - 35'(b_y);
      wa_r   <= a_w;
      wb_r   <= b_w;
      s6_side_r.vis <= s5_side_r.vis;
      s6_side_r.seg <= s5_side_r.seg;
    end
  end

  // panel lanes
  spnc_panel #(.FRAC_BITS(FRAC_BITS), .SW($bits(pan_side_t))) u_pan_sx (
    .clk(clk), .rst_n(rst_n), .en(en), .num(num0_r), .w(wa_r), .lo(vp_minx),
    .size(vp_wid), .side_in(s6_side_r), .res(r0), .side_out(pside_v));
  spnc_panel #(.FRAC_BITS(FRAC_BITS), .SW($bits(pan_side_t))) u_pan_sy (
    .clk(clk), .rst_n(rst_n), .en(en), .num(num1_r), .w(wa_r), .lo(vp_miny),
    .size(vp_hgt), .side_in('0), .res(r1), .side_out());
  spnc_panel #(.FRAC_BITS(FRAC_BITS), .SW($bits(pan_side_t))) u_pan_ex (
    .clk(clk), .rst_n(rst_n), .en(en), .num(num2_r), .w(wb_r), .lo(vp_minx),
    .size(vp_wid), .side_in('0), .res(r2), .side_out());
  spnc_panel #(.FRAC_BITS(FRAC_BITS), .SW($bits(pan_side_t))) u_pan_ey (
    .clk(clk), .rst_n(rst_n), .en(en), .num(num3_r), .w(wb_r), .lo(vp_miny),
    .size(vp_hgt), .side_in('0), .res(r3), .side_out());

  // merge lanes into one result
  always_comb begin
    pside       = pan_side_t'(pside_v);
    pd.visible  = pside.vis;
    pd.start_px = pside.vis ? r0 : '0;
    pd.start_py = pside.vis ? r1 : '0;
    pd.end_px   = (pside.vis && pside.seg) ? r2 : '0;
    pd.end_py   = (pside.vis && pside.seg) ? r3 : '0;
  end

  // output register with skid
  assign out_free  = !out_v_r || out_ch.ready;
  assign pipe_push = en && pside.v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= pipe_push;
      end
    end else if (pipe_push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_d_r <= skid_v_r ? skid_d_r : pd;
    end else if (pipe_push) begin
      skid_d_r <= pd;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_d_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a result while the output register is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_ch.ready))
    else $error("skid filled without an output stall");

  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_d_r.visible) |-> (out_d_r.start_px == '0 &&
      out_d_r.start_py == '0 && out_d_r.end_px == '0 && out_d_r.end_py == '0))
    else $error("hidden result carries non-zero coordinates");

endmodule
